// ----- hdl/windowed_pid_controller_assert.svh -----
// Assertion helpers shared by the controller's RTL.
`ifndef WINDOWED_PID_CONTROLLER_ASSERT_SVH
`define WINDOWED_PID_CONTROLLER_ASSERT_SVH

// Clocked check, held off while reset is asserted.
`define WPID_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked check that also holds during reset.
`define WPID_CHECK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ----- hdl/wpid_pkg.sv -----
`timescale 1ns / 1ps

package wpid_pkg;

    localparam int ERR_W     = 16;
    localparam int GAIN_W    = 16;
    localparam int LIMIT_W   = 23;
    localparam int SUM_W     = 24;
    localparam int DIFF_W    = ERR_W + 1;
    localparam int DRIVE_W   = 32;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 4;

    localparam int HISTORY_DEPTH_DEF = 32;
    localparam int DERIV_SPAN_DEF    = 4;
    localparam int QUEUE_DEPTH       = 4;

    localparam logic [1:0] REG_PROP_GAIN  = 2'd0;
    localparam logic [1:0] REG_INTEG_GAIN = 2'd1;
    localparam logic [1:0] REG_DERIV_GAIN = 2'd2;
    localparam logic [1:0] REG_INTEG_LIM  = 2'd3;

    localparam logic signed [GAIN_W-1:0] PROP_GAIN_RST  = 16'sd256;
    localparam logic signed [GAIN_W-1:0] INTEG_GAIN_RST = 16'sd0;
    localparam logic signed [GAIN_W-1:0] DERIV_GAIN_RST = 16'sd0;
    localparam logic [LIMIT_W-1:0]       INTEG_LIM_RST  = 23'h7F_FFFF;

    typedef struct packed {
        logic signed [GAIN_W-1:0] prop_gain;
        logic signed [GAIN_W-1:0] integ_gain;
        logic signed [GAIN_W-1:0] deriv_gain;
        logic [LIMIT_W-1:0]       integral_limit;
    } cfg_t;

    // Whether each ring read hits an entry written since reset.
    typedef struct packed {
        logic slot_valid;
        logic back_valid;
    } hist_flags_t;

endpackage

// ----- hdl/wpid_ifs.sv -----
`timescale 1ns / 1ps

interface wpid_in_if;
    import wpid_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [ERR_W-1:0] error_sample;

    modport source (output valid, output error_sample, input ready);
    modport sink   (input valid, input error_sample, output ready);
endinterface

interface wpid_out_if;
    import wpid_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [DRIVE_W-1:0] drive_value;

    modport source (output valid, output drive_value, input ready);
    modport sink   (input valid, input drive_value, output ready);
endinterface

// ----- hdl/windowed_pid_controller.sv -----
`timescale 1ns / 1ps
// Windowed PID controller: takes one signed error sample per transaction and returns one
// saturated drive value, (P + I + D) >>> 8, with the integral taken as a clamped running sum
// over the last HISTORY_DEPTH samples and the derivative as the difference to the sample
// DERIV_SPAN ticks back. Sustained rate is one sample per clock unless the output stalls.
// Past the queue, a sample moves through execute, multiply, product and output registers.
// The rate is set by the running sum update, which adds and clamps combinationally, and by
// the history ring, a RAM with two registered read ports and one write port; a lag of one
// tick is forwarded around the ring write. A four-entry queue separates intake from the
// arithmetic pipeline, so samples keep flowing while a result waits to be taken. The ring
// reads as zero until each entry is first written, tracked by fill position, so there is
// no clearing pass after reset. Gains and the integral limit sit on the APB port at byte
// addresses 0, 4, 8 and 12 and may be changed only while the controller is idle.

module windowed_pid_controller
    import wpid_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int DERIV_SPAN    = DERIV_SPAN_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    wpid_in_if.sink           samples,
    wpid_out_if.source        drives,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int ADDR_W = $clog2(HISTORY_DEPTH);
    localparam int FLAG_W = $bits(hist_flags_t);
    localparam int Q_W    = ERR_W + 2 * ADDR_W + FLAG_W;

    cfg_t cfg_reg;
    logic [1:0] reg_idx;
    logic       cfg_wr;

    logic                    push;
    logic signed [ERR_W-1:0] f_err;
    logic [ADDR_W-1:0]       f_slot;
    logic [ADDR_W-1:0]       f_back;
    hist_flags_t             f_flags;

    logic                    q_full;
    logic                    q_valid;
    logic                    q_pop;
    logic [Q_W-1:0]          q_head;
    logic signed [ERR_W-1:0] q_err;
    logic [ADDR_W-1:0]       q_slot;
    logic [ADDR_W-1:0]       q_back;
    hist_flags_t             q_flags;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain      <= PROP_GAIN_RST;
            cfg_reg.integ_gain     <= INTEG_GAIN_RST;
            cfg_reg.deriv_gain     <= DERIV_GAIN_RST;
            cfg_reg.integral_limit <= INTEG_LIM_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_PROP_GAIN:  cfg_reg.prop_gain      <= $signed(pwdata[GAIN_W-1:0]);
                REG_INTEG_GAIN: cfg_reg.integ_gain     <= $signed(pwdata[GAIN_W-1:0]);
                REG_DERIV_GAIN: cfg_reg.deriv_gain     <= $signed(pwdata[GAIN_W-1:0]);
                REG_INTEG_LIM:  cfg_reg.integral_limit <= pwdata[LIMIT_W-1:0];
                default:        cfg_reg                <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_PROP_GAIN:  prdata = APB_DW'(cfg_reg.prop_gain);
            REG_INTEG_GAIN: prdata = APB_DW'(cfg_reg.integ_gain);
            REG_DERIV_GAIN: prdata = APB_DW'(cfg_reg.deriv_gain);
            REG_INTEG_LIM:  prdata = APB_DW'(cfg_reg.integral_limit);
            default:        prdata = '0;
        endcase
    end

    wpid_front #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .DERIV_SPAN    (DERIV_SPAN)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .q_full  (q_full),
        .push    (push),
        .err     (f_err),
        .slot    (f_slot),
        .back    (f_back),
        .flags   (f_flags)
    );

    wpid_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  ({f_err, f_slot, f_back, f_flags}),
        .pop        (q_pop),
        .head_data  (q_head),
        .head_valid (q_valid),
        .full       (q_full)
    );

    assign {q_err, q_slot, q_back, q_flags} = q_head;

    wpid_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_err   (q_err),
        .q_slot  (q_slot),
        .q_back  (q_back),
        .q_flags (q_flags),
        .q_pop   (q_pop),
        .drives  (drives)
    );

endmodule

// ----- hdl/wpid_ram.sv -----
`timescale 1ns / 1ps

module wpid_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ----- hdl/wpid_queue.sv -----
`timescale 1ns / 1ps
`include "windowed_pid_controller_assert.svh"

module wpid_queue #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             head_valid,
    output logic             full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign head_data  = slots[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == FULL_CNT);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

    `WPID_CHECK_ALWAYS(a_no_push_when_full, !(push && full), "push into a full queue")
    `WPID_CHECK(a_no_pop_when_empty, pop |-> head_valid, "pop from an empty queue")

endmodule

// ----- hdl/wpid_front.sv -----
`timescale 1ns / 1ps
`include "windowed_pid_controller_assert.svh"

module wpid_front
    import wpid_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int DERIV_SPAN    = DERIV_SPAN_DEF,
    localparam int ADDR_W       = $clog2(HISTORY_DEPTH)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    wpid_in_if.sink                 samples,
    input  logic                    q_full,
    output logic                    push,
    output logic signed [ERR_W-1:0] err,
    output logic [ADDR_W-1:0]       slot,
    output logic [ADDR_W-1:0]       back,
    output hist_flags_t             flags
);

    localparam int LAG = DERIV_SPAN % HISTORY_DEPTH;
    localparam logic [ADDR_W:0]   LAG_V     = (ADDR_W + 1)'(LAG);
    localparam logic [ADDR_W:0]   DEPTH_V   = (ADDR_W + 1)'(HISTORY_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(HISTORY_DEPTH - 1);

    logic [ADDR_W-1:0] write_slot_reg, write_slot_next;
    logic              wrapped_reg, wrapped_next;
    logic [ADDR_W:0]   slot_ext;
    logic [ADDR_W:0]   back_ext;

    assign samples.ready = !q_full;
    assign push          = samples.valid && !q_full;
    assign err           = samples.error_sample;
    assign slot          = write_slot_reg;

    always_comb
    begin
        slot_ext = {1'b0, write_slot_reg};
        if (slot_ext >= LAG_V)
        begin
            back_ext = slot_ext - LAG_V;
        end
        else
        begin
            back_ext = slot_ext + DEPTH_V - LAG_V;
        end
        back = back_ext[ADDR_W-1:0];
        // Slots fill in order, so anything below the write slot has been written.
        flags.slot_valid = wrapped_reg;
        flags.back_valid = wrapped_reg || (back_ext < slot_ext);
    end

    always_comb
    begin
        write_slot_next = write_slot_reg;
        wrapped_next    = wrapped_reg;
        if (push)
        begin
            if (write_slot_reg == LAST_SLOT)
            begin
                write_slot_next = '0;
                wrapped_next    = 1'b1;
            end
            else
            begin
                write_slot_next = write_slot_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_slot_reg <= '0;
            wrapped_reg    <= 1'b0;
        end
        else
        begin
            write_slot_reg <= write_slot_next;
            wrapped_reg    <= wrapped_next;
        end
    end

    `WPID_CHECK(a_wrap_sticky, wrapped_reg |=> wrapped_reg, "ring fill flag dropped")

endmodule

// ----- hdl/wpid_back.sv -----
`timescale 1ns / 1ps
`include "windowed_pid_controller_assert.svh"

module wpid_back
    import wpid_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    localparam int ADDR_W       = $clog2(HISTORY_DEPTH)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  logic                    q_valid,
    input  logic signed [ERR_W-1:0] q_err,
    input  logic [ADDR_W-1:0]       q_slot,
    input  logic [ADDR_W-1:0]       q_back,
    input  hist_flags_t             q_flags,
    output logic                    q_pop,
    wpid_out_if.source              drives
);

    localparam int RAW_W  = SUM_W + 2;
    localparam int PP_W   = ERR_W + GAIN_W;
    localparam int PI_W   = SUM_W + GAIN_W;
    localparam int PD_W   = DIFF_W + GAIN_W;
    localparam int TOT_W  = PI_W + 2;
    localparam int SHR    = 8;
    localparam int SHT_W  = TOT_W - SHR;

    // Pipeline control
    logic advance;
    logic e_fire;

    // Execute stage: ring data arrives with the item
    logic                    e_valid_reg;
    logic signed [ERR_W-1:0] e_err_reg;
    logic [ADDR_W-1:0]       e_slot_reg;
    hist_flags_t             e_flags_reg;
    logic                    e_fwd_reg;
    logic signed [ERR_W-1:0] e_fwd_err_reg;

    logic [ERR_W-1:0]        rd_old;
    logic [ERR_W-1:0]        rd_back;
    logic signed [ERR_W-1:0] old_val;
    logic signed [ERR_W-1:0] back_val;
    logic signed [RAW_W-1:0] sum_raw;
    logic signed [RAW_W-1:0] lim_pos;
    logic signed [RAW_W-1:0] lim_neg;
    logic signed [SUM_W-1:0] sum_clamp;
    logic signed [DIFF_W-1:0] diff;

    logic signed [SUM_W-1:0] running_sum_reg;
    logic signed [RAW_W-1:0] sum_ext;

    // Multiply operands
    logic                     m_valid_reg;
    logic signed [ERR_W-1:0]  m_err_reg;
    logic signed [SUM_W-1:0]  m_sum_reg;
    logic signed [DIFF_W-1:0] m_diff_reg;

    // Products
    logic                    p_valid_reg;
    logic signed [PP_W-1:0]  p_prop_reg;
    logic signed [PI_W-1:0]  p_int_reg;
    logic signed [PD_W-1:0]  p_der_reg;
    logic signed [PP_W-1:0]  p_prop_next;
    logic signed [PI_W-1:0]  p_int_next;
    logic signed [PD_W-1:0]  p_der_next;

    logic signed [TOT_W-1:0]   total;
    logic signed [SHT_W-1:0]   shifted;
    logic signed [DRIVE_W-1:0] drive_next;

    logic                      out_valid_reg;
    logic signed [DRIVE_W-1:0] drive_reg;

    assign advance = !out_valid_reg || drives.ready;
    assign q_pop   = advance && q_valid;
    assign e_fire  = advance && e_valid_reg;
    assign sum_ext = RAW_W'(running_sum_reg);

    wpid_ram #(
        .WIDTH (ERR_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_ring (
        .clk     (clk),
        .we      (e_fire),
        .waddr   (e_slot_reg),
        .wdata   (e_err_reg),
        .re      (q_pop),
        .raddr_a (q_slot),
        .raddr_b (q_back),
        .rdata_a (rd_old),
        .rdata_b (rd_back)
    );

    always_comb
    begin
        // Unwritten ring entries read as zero.
        old_val = e_flags_reg.slot_valid ? $signed(rd_old) : '0;
        if (e_fwd_reg)
        begin
            back_val = e_fwd_err_reg;
        end
        else
        begin
            back_val = e_flags_reg.back_valid ? $signed(rd_back) : '0;
        end

        sum_raw = RAW_W'(running_sum_reg) - RAW_W'(old_val) + RAW_W'(e_err_reg);
        lim_pos = $signed({3'b000, cfg.integral_limit});
        lim_neg = -lim_pos;
        if (sum_raw > lim_pos)
        begin
            sum_clamp = lim_pos[SUM_W-1:0];
        end
        else if (sum_raw < lim_neg)
        begin
            sum_clamp = lim_neg[SUM_W-1:0];
        end
        else
        begin
            sum_clamp = sum_raw[SUM_W-1:0];
        end
        diff = DIFF_W'(e_err_reg) - DIFF_W'(back_val);
    end

    always_comb
    begin
        p_prop_next = m_err_reg * cfg.prop_gain;
        p_int_next  = m_sum_reg * cfg.integ_gain;
        p_der_next  = m_diff_reg * cfg.deriv_gain;
    end

    always_comb
    begin
        total   = TOT_W'(p_prop_reg) + TOT_W'(p_int_reg) + TOT_W'(p_der_reg);
        shifted = total[TOT_W-1:SHR];
        // Saturate when the bits above the sign do not all agree.
        if (shifted[SHT_W-1:DRIVE_W-1] == '0 || shifted[SHT_W-1:DRIVE_W-1] == '1)
        begin
            drive_next = shifted[DRIVE_W-1:0];
        end
        else if (shifted[SHT_W-1])
        begin
            drive_next = {1'b1, {(DRIVE_W - 1){1'b0}}};
        end
        else
        begin
            drive_next = {1'b0, {(DRIVE_W - 1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg     <= 1'b0;
            m_valid_reg     <= 1'b0;
            p_valid_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            running_sum_reg <= '0;
        end
        else if (advance)
        begin
            e_valid_reg   <= q_pop;
            m_valid_reg   <= e_valid_reg;
            p_valid_reg   <= m_valid_reg;
            out_valid_reg <= p_valid_reg;
            if (e_valid_reg)
            begin
                running_sum_reg <= sum_clamp;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (q_pop)
            begin
                e_err_reg     <= q_err;
                e_slot_reg    <= q_slot;
                e_flags_reg   <= q_flags;
                // Ring write of the item ahead lands on this very edge: forward it.
                e_fwd_reg     <= e_valid_reg && (e_slot_reg == q_back);
                e_fwd_err_reg <= e_err_reg;
            end
            m_err_reg  <= e_err_reg;
            m_sum_reg  <= sum_clamp;
            m_diff_reg <= diff;
            p_prop_reg <= p_prop_next;
            p_int_reg  <= p_int_next;
            p_der_reg  <= p_der_next;
            if (p_valid_reg)
            begin
                drive_reg <= drive_next;
            end
        end
    end

    assign drives.valid       = out_valid_reg;
    assign drives.drive_value = drive_reg;

    `WPID_CHECK(a_sum_clamped, e_fire |=> (sum_ext <= $past(lim_pos) && sum_ext >= $past(lim_neg)), "sum outside clamp")

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import wpid_pkg::*;

    localparam int RING_DEPTH   = HISTORY_DEPTH_DEF;
    localparam int RING_LAG     = DERIV_SPAN_DEF % HISTORY_DEPTH_DEF;
    localparam int PHASE_COUNT  = 8;
    localparam int PHASE_ITEMS  = 215;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 12;

    // One row of the directed table: either a register write or a sample,
    // with the drive value typed in where it is obvious.
    typedef struct packed {
        logic                      cfg_row;
        logic [1:0]                reg_idx;
        logic [APB_DW-1:0]         wdata;
        logic signed [ERR_W-1:0]   err;
        logic                      typed;
        logic signed [DRIVE_W-1:0] drive;
    } step_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    wpid_in_if  sample_ch ();
    wpid_out_if drive_ch ();

    windowed_pid_controller dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .drives  (drive_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Controller mirror
    cfg_t                    ctl;
    logic signed [ERR_W-1:0] err_ring [RING_DEPTH];
    int                      ring_pos;
    int                      win_sum;

    logic signed [DRIVE_W-1:0] expected_drives [$];
    int  mismatches;
    int  quiet_cycles;
    int  hold_left;
    bit  hold_req;
    bit  burst;

    step_t directed_steps [28] = '{
        '{1'b0, REG_PROP_GAIN,  32'd0,        16'sd0,     1'b1, 32'sd0},
        '{1'b0, REG_PROP_GAIN,  32'd0,        16'sh7FFF,  1'b1, 32'sh0000_7FFF},
        '{1'b0, REG_PROP_GAIN,  32'd0,        16'sh8000,  1'b1, 32'shFFFF_8000},
        '{1'b0, REG_PROP_GAIN,  32'd0,        16'shFFFF,  1'b1, 32'shFFFF_FFFF},
        '{1'b0, REG_PROP_GAIN,  32'd0,        16'sd1,     1'b1, 32'sd1},
        '{1'b0, REG_PROP_GAIN,  32'd0,        16'sh5555,  1'b1, 32'sh0000_5555},
        '{1'b0, REG_PROP_GAIN,  32'd0,        16'shAAAA,  1'b1, 32'shFFFF_AAAA},
        '{1'b1, REG_INTEG_GAIN, 32'h0000_0100, 16'sd0,    1'b0, 32'sd0},
        '{1'b1, REG_INTEG_LIM,  32'h0000_0100, 16'sd0,    1'b0, 32'sd0},
        '{1'b0, REG_PROP_GAIN,  32'd0,        16'sh7FFF,  1'b0, 32'sd0},
        '{1'b0, REG_PROP_GAIN,  32'd0,        16'sh7FFF,  1'b0, 32'sd0},
        '{1'b0, REG_PROP_GAIN,  32'd0,        16'sh8000,  1'b0, 32'sd0},
        '{1'b0, REG_PROP_GAIN,  32'd0,        16'sh8000,  1'b0, 32'sd0},
        '{1'b0, REG_PROP_GAIN,  32'd0,        16'sh8000,  1'b0, 32'sd0},
        '{1'b1, REG_DERIV_GAIN, 32'h0000_0100, 16'sd0,    1'b0, 32'sd0},
        '{1'b1, REG_INTEG_LIM,  32'h0000_0000, 16'sd0,    1'b0, 32'sd0},
        '{1'b0, REG_PROP_GAIN,  32'd0,        16'sd100,   1'b0, 32'sd0},
        '{1'b0, REG_PROP_GAIN,  32'd0,        16'shFF9C,  1'b0, 32'sd0},
        '{1'b0, REG_PROP_GAIN,  32'd0,        16'sh7FFF,  1'b0, 32'sd0},
        '{1'b0, REG_PROP_GAIN,  32'd0,        16'sh8000,  1'b0, 32'sd0},
        '{1'b1, REG_PROP_GAIN,  32'hFFFF_8000, 16'sd0,    1'b0, 32'sd0},
        '{1'b1, REG_INTEG_GAIN, 32'h0000_7FFF, 16'sd0,    1'b0, 32'sd0},
        '{1'b1, REG_DERIV_GAIN, 32'hA5A5_8000, 16'sd0,    1'b0, 32'sd0},
        '{1'b1, REG_INTEG_LIM,  32'hFF7F_FFFF, 16'sd0,    1'b0, 32'sd0},
        '{1'b0, REG_PROP_GAIN,  32'd0,        16'sh7FFF,  1'b0, 32'sd0},
        '{1'b0, REG_PROP_GAIN,  32'd0,        16'sh8000,  1'b0, 32'sd0},
        '{1'b0, REG_PROP_GAIN,  32'd0,        16'sh7FFF,  1'b0, 32'sd0},
        '{1'b0, REG_PROP_GAIN,  32'd0,        16'sh8000,  1'b0, 32'sd0}
    };

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Advance the mirror by one sample and return the drive value it gives.
    function automatic logic signed [DRIVE_W-1:0] next_drive(input logic signed [ERR_W-1:0] err);
        int     lag_idx;
        int     diff;
        longint acc;
        longint total;
        longint scaled;
        lag_idx = (ring_pos + RING_DEPTH - RING_LAG) % RING_DEPTH;
        acc = longint'(win_sum) - longint'(err_ring[ring_pos]) + longint'(err);
        if (acc > longint'(ctl.integral_limit))
            acc = longint'(ctl.integral_limit);
        else if (acc < -longint'(ctl.integral_limit))
            acc = -longint'(ctl.integral_limit);
        win_sum = int'(acc);
        // read the lagged entry before the write, so a zero lag sees the old value
        diff = int'(err) - int'(err_ring[lag_idx]);
        err_ring[ring_pos] = err;
        ring_pos = (ring_pos + 1) % RING_DEPTH;
        total = longint'(err) * longint'(ctl.prop_gain)
              + longint'(win_sum) * longint'(ctl.integ_gain)
              + longint'(diff) * longint'(ctl.deriv_gain);
        scaled = total >>> 8;
        if (scaled > 64'sd2147483647)
            scaled = 64'sd2147483647;
        else if (scaled < -64'sd2147483648)
            scaled = -64'sd2147483648;
        return scaled[DRIVE_W-1:0];
    endfunction

    function automatic logic signed [ERR_W-1:0] pick_error();
        int r;
        int v;
        r = $urandom_range(99);
        if (r < 35)
            v = $urandom;
        else if (r < 70)
            v = int'($urandom_range(1000)) - 500;
        else if (r < 85)
            v = 32767 - int'($urandom_range(31));
        else
            v = -32768 + int'($urandom_range(31));
        return v[ERR_W-1:0];
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PROP_GAIN:  ctl.prop_gain = value[GAIN_W-1:0];
            REG_INTEG_GAIN: ctl.integ_gain = value[GAIN_W-1:0];
            REG_DERIV_GAIN: ctl.deriv_gain = value[GAIN_W-1:0];
            REG_INTEG_LIM:  ctl.integral_limit = value[LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_sample(input logic signed [ERR_W-1:0] err, input bit typed,
                               input logic signed [DRIVE_W-1:0] typed_drive);
        logic signed [DRIVE_W-1:0] want;
        while (!burst && $urandom_range(99) < 18)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid        <= 1'b1;
        sample_ch.error_sample <= err;
        do @(posedge clk); while (!sample_ch.ready);
        want = next_drive(err);
        expected_drives.push_back(typed ? typed_drive : want);
    endtask

    // Drop valid and wait until every outstanding drive value has come back.
    task automatic settle();
        sample_ch.valid <= 1'b0;
        while (expected_drives.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin : drive_sink
        logic signed [DRIVE_W-1:0] want;
        if (!rst_n)
            drive_ch.ready <= 1'b0;
        else
        begin
            if (drive_ch.valid && drive_ch.ready)
            begin
                if (expected_drives.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected drive_value %0d", drive_ch.drive_value);
                end
                else
                begin
                    want = expected_drives.pop_front();
                    if (drive_ch.drive_value !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("drive_value mismatch: expected %0d, got %0d",
                                     want, drive_ch.drive_value);
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                drive_ch.ready <= 1'b0;
            end
            else if (hold_req)
            begin
                // long back-pressure so the intake queue fills and stalls
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
                drive_ch.ready <= 1'b0;
            end
            else
                drive_ch.ready <= burst || ($urandom_range(99) >= 18);
        end
    end

    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (drive_ch.valid && drive_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[windowed_pid_controller] ERROR");
            $finish;
        end
    end

    initial
    begin
        cfg_t              pick;
        logic [APB_DW-1:0] noise;
        rst_n                  = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        sample_ch.valid        = 1'b0;
        sample_ch.error_sample = '0;
        drive_ch.ready         = 1'b0;
        mismatches             = 0;
        quiet_cycles           = 0;
        hold_left              = 0;
        hold_req               = 1'b0;
        burst                  = 1'b0;
        ctl.prop_gain          = PROP_GAIN_RST;
        ctl.integ_gain         = INTEG_GAIN_RST;
        ctl.deriv_gain         = DERIV_GAIN_RST;
        ctl.integral_limit     = INTEG_LIM_RST;
        ring_pos               = 0;
        win_sum                = 0;
        for (int i = 0; i < RING_DEPTH; i++)
            err_ring[i] = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_steps[i])
        begin
            if (directed_steps[i].cfg_row)
            begin
                settle();
                write_reg(directed_steps[i].reg_idx, directed_steps[i].wdata);
            end
            else
                send_sample(directed_steps[i].err, directed_steps[i].typed,
                            directed_steps[i].drive);
        end

        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            settle();
            pick.prop_gain      = GAIN_W'($urandom);
            pick.integ_gain     = GAIN_W'($urandom);
            pick.deriv_gain     = GAIN_W'($urandom);
            pick.integral_limit = LIMIT_W'($urandom);
            case (ph)
                0: pick = '{16'sd256, 16'sd64, 16'sd128, 23'd5000};
                1: pick = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 23'h7F_FFFF};
                2: pick = '{16'sh8000, 16'sh8000, 16'sh8000, 23'h7F_FFFF};
                3: pick.integral_limit = '0;
                4: pick.integral_limit = 23'd1;
                6: pick.integral_limit = LIMIT_W'($urandom_range(100000));
                7:
                begin
                    pick.prop_gain  = '0;
                    pick.integ_gain = '0;
                    pick.deriv_gain = '0;
                end
                default: ;
            endcase
            noise = $urandom;
            write_reg(REG_PROP_GAIN, {noise[31:16], pick.prop_gain});
            write_reg(REG_INTEG_GAIN, {noise[15:0], pick.integ_gain});
            write_reg(REG_DERIV_GAIN, {noise[23:8], pick.deriv_gain});
            write_reg(REG_INTEG_LIM, {noise[31:23], pick.integral_limit});
            burst = (ph == 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == 5 && n == 40)
                    hold_req = 1'b1;
                if (ph == 6 && n == 100)
                    settle();
                send_sample(pick_error(), 1'b0, '0);
            end
        end
        burst = 1'b0;
        settle();

        if (mismatches == 0 && expected_drives.size() == 0)
            $display("[windowed_pid_controller] OK");
        else
            $display("[windowed_pid_controller] ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/wpid_pkg.sv
hdl/wpid_ifs.sv
hdl/wpid_ram.sv
hdl/wpid_queue.sv
hdl/wpid_front.sv
hdl/wpid_back.sv
hdl/windowed_pid_controller.sv
verif/testbench.sv
